// ----- hdl/gamepad_report_conditioner_macros.svh -----
// assertion macros shared by the gamepad report conditioner rtl
// no dependencies; the including module must provide clk and rst_n
`ifndef GAMEPAD_REPORT_CONDITIONER_MACROS_SVH
`define GAMEPAD_REPORT_CONDITIONER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define GRC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, sampled on clk, off during reset
`define GRC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GRC_ASSERT_IMP(label, ante, cons, msg)
`define GRC_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ----- hdl/grc_pkg.sv -----
// shared types and constants of the gamepad report conditioner
// no dependencies
`timescale 1ns / 1ps
package grc_pkg;

  localparam int unsigned PLAYER_COUNT_DEF = 4;
  localparam logic [14:0] FULL_SCALE       = 15'h7FFF;
  localparam logic [7:0]  TRIGGER_MAX      = 8'hFF;

  // configuration reset values
  localparam logic [14:0] LEFT_DZ_RST  = 15'd7849;
  localparam logic [14:0] RIGHT_DZ_RST = 15'd8689;
  localparam logic [7:0]  TRIG_TH_RST  = 8'd30;

  // configuration register indexes (byte address / 4)
  localparam logic [1:0] REG_LEFT_DZ  = 2'd0;
  localparam logic [1:0] REG_RIGHT_DZ = 2'd1;
  localparam logic [1:0] REG_TRIG_TH  = 2'd2;

  // stick lane sequencer
  typedef enum logic [3:0] {
    ST_IDLE, ST_SQR, ST_SUM, ST_ROOT, ST_CHK, ST_MUL, ST_DIVI, ST_DIV, ST_RES
  } grc_stk_state_t;

  // top level sequencer
  typedef enum logic [0:0] {
    S_IDLE, S_RUN
  } grc_top_state_t;

  // stick lane status and result
  typedef struct packed {
    logic        busy;
    logic [15:0] x_level;
    logic [15:0] y_level;
  } grc_stick_res_t;

  // trigger lane status and result
  typedef struct packed {
    logic        busy;
    logic [14:0] level;
  } grc_trig_res_t;

endpackage

// ----- hdl/grc_trigger_lane.sv -----
// trigger lane: threshold deadzone and rescale by restoring division
// depends on grc_pkg
`timescale 1ns / 1ps
module grc_trigger_lane
  import grc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [7:0]    raw,
  input  logic [7:0]    threshold,
  output grc_trig_res_t res
);

  logic        busy_r;
  logic [3:0]  cnt_r;
  logic [7:0]  rem_r;
  logic [7:0]  den_r;
  logic [14:0] q_r;
  logic        zero_r;
  logic        sat_r;
  logic [14:0] level_r;
  logic [8:0]  rem2;

  assign rem2 = {rem_r, 1'b0};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 4'd14;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 4'd1;
      if (cnt_r == 4'd0) begin
        busy_r <= 1'b0;
      end
    end
  end

  // one quotient bit per cycle; remainder stays below the divisor while threshold < raw < 255
  always_ff @(posedge clk) begin
    if (start) begin
      zero_r <= !(raw > threshold);
      sat_r  <= (raw == TRIGGER_MAX);
      rem_r  <= raw - threshold;
      den_r  <= TRIGGER_MAX - threshold;
      q_r    <= 15'd0;
    end else if (busy_r) begin
      if (rem2 >= {1'b0, den_r}) begin
        rem_r <= 8'(rem2 - {1'b0, den_r});
        q_r   <= {q_r[13:0], 1'b1};
      end else begin
        rem_r <= rem2[7:0];
        q_r   <= {q_r[13:0], 1'b0};
      end
      if (cnt_r == 4'd0) begin
        level_r <= zero_r ? 15'd0 : (sat_r ? FULL_SCALE : {q_r[13:0], rem2 >= {1'b0, den_r}});
      end
    end
  end

  assign res.busy  = busy_r;
  assign res.level = level_r;

endmodule

// ----- hdl/grc_stick_lane.sv -----
// stick lane: radial deadzone with iterative square root and two dividers
// depends on grc_pkg
`timescale 1ns / 1ps
module grc_stick_lane
  import grc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [15:0]  x,
  input  logic signed [15:0]  y,
  input  logic [14:0]         deadzone,
  output grc_stick_res_t      res
);

  grc_stk_state_t state_r, state_nxt;
  logic [4:0]        cnt_r;
  logic [1:0][15:0]  a_r;
  logic [1:0]        neg_r;
  logic [1:0][31:0]  sq_r;
  logic [29:0]       dzsq_r;
  logic [29:0]       den_r;
  logic [31:0]       ssum_r;
  logic [31:0]       srem_r;
  logic [31:0]       root_r;
  logic [31:0]       bit_r;
  logic [14:0]       d_r;
  logic [1:0][30:0]  prod_r;
  logic [1:0][45:0]  rem_r;
  logic [46:0]       dv_r;
  logic [1:0][16:0]  q_r;
  logic [1:0]        ovf_r;
  logic [1:0][15:0]  lvl_r;
  logic [14:0]       dzc;
  logic [31:0]       trial;
  logic [14:0]       mag;
  logic              zero;
  logic [1:0][16:0]  qc;

  assign dzc   = FULL_SCALE - deadzone;
  assign trial = root_r + bit_r;
  assign mag   = (root_r > 32'(FULL_SCALE)) ? FULL_SCALE : root_r[14:0];
  assign zero  = (ssum_r <= {2'b00, dzsq_r}) || (mag <= deadzone) ||
                 (deadzone == FULL_SCALE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_SQR;
      ST_SQR:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_ROOT;
      ST_ROOT: if (cnt_r == 5'd0) state_nxt = ST_CHK;
      ST_CHK:  state_nxt = zero ? ST_IDLE : ST_MUL;
      ST_MUL:  state_nxt = ST_DIVI;
      ST_DIVI: state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == 5'd0) state_nxt = ST_RES;
      ST_RES:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    res.busy    = (state_r != ST_IDLE);
    res.x_level = lvl_r[0];
    res.y_level = lvl_r[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // saturated quotients, -1.0 floor for negative axes
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (neg_r[k]) begin
        qc[k] = (ovf_r[k] || q_r[k] > 17'd32768) ? 17'd32768 : q_r[k];
      end else begin
        qc[k] = (ovf_r[k] || q_r[k] > 17'd32767) ? 17'd32767 : q_r[k];
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          a_r[0]   <= x[15] ? 16'(-x) : 16'(x);
          a_r[1]   <= y[15] ? 16'(-y) : 16'(y);
          neg_r[0] <= x[15];
          neg_r[1] <= y[15];
        end
      end
      ST_SQR: begin
        for (int k = 0; k < 2; k++) begin
          sq_r[k] <= 32'(a_r[k]) * 32'(a_r[k]);
        end
        dzsq_r <= 30'(deadzone) * 30'(deadzone);
        den_r  <= 30'({dzc, 15'd0}) - 30'(dzc);
      end
      ST_SUM: begin
        ssum_r <= sq_r[0] + sq_r[1];
        srem_r <= sq_r[0] + sq_r[1];
        root_r <= 32'd0;
        bit_r  <= 32'h4000_0000;
        cnt_r  <= 5'd15;
      end
      // two radicand bits per step, one root bit
      ST_ROOT: begin
        if (srem_r >= trial) begin
          srem_r <= srem_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 5'd1;
      end
      ST_CHK: begin
        d_r <= mag - deadzone;
        if (zero) begin
          lvl_r <= '0;
        end
      end
      ST_MUL: begin
        for (int k = 0; k < 2; k++) begin
          prod_r[k] <= 31'(a_r[k]) * 31'(d_r);
        end
      end
      ST_DIVI: begin
        for (int k = 0; k < 2; k++) begin
          rem_r[k] <= {prod_r[k], 15'd0};
          ovf_r[k] <= {1'b0, prod_r[k], 15'd0} >= {den_r, 17'd0};
          q_r[k]   <= 17'd0;
        end
        dv_r  <= {1'b0, den_r, 16'd0};
        cnt_r <= 5'd16;
      end
      // restoring division, both axes side by side
      ST_DIV: begin
        for (int k = 0; k < 2; k++) begin
          if ({1'b0, rem_r[k]} >= dv_r) begin
            rem_r[k] <= 46'({1'b0, rem_r[k]} - dv_r);
            q_r[k]   <= {q_r[k][15:0], 1'b1};
          end else begin
            q_r[k] <= {q_r[k][15:0], 1'b0};
          end
        end
        dv_r  <= dv_r >> 1;
        cnt_r <= cnt_r - 5'd1;
      end
      ST_RES: begin
        for (int k = 0; k < 2; k++) begin
          lvl_r[k] <= neg_r[k] ? 16'(16'd0 - qc[k][15:0]) : qc[k][15:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hdl/gamepad_report_conditioner.sv -----
// Gamepad report conditioner, top level.
// One raw controller report is a transfer on the in_ stream; one
// conditioned result is a transfer on the out_ stream, in order.
// Registers (APB): 0x0 left stick deadzone, 0x4 right stick deadzone,
// 0x8 trigger threshold; write only while the block is idle.
// The stick lanes set the pace: square and sum, 16 square root steps,
// check, multiply and load the dividers, 17 restoring division steps
// for both axes at once, saturation, then the output register; a stick
// inside its deadzone ends after the check.
// A new report is taken while the previous result still waits in the
// output register.
// If the receiver stalls, the finished result waits in the lanes and the
// next report is held off until the output register frees up.
// Reset (synchronous) clears the button history of every player, loads
// the register defaults and empties the output.
// Depends on grc_pkg, grc_stick_lane, grc_trigger_lane and the macro header.
`timescale 1ns / 1ps
`include "gamepad_report_conditioner_macros.svh"
module gamepad_report_conditioner
  import grc_pkg::*;
#(
  parameter int unsigned PlayerCount = PLAYER_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  // player, connected, raw_buttons, raw_left_trigger, raw_right_trigger,
  // raw_left_x, raw_left_y, raw_right_x, raw_right_y, zero fill
  input  logic [103:0]  in_tdata,
  input  logic          in_tvalid,
  output logic          in_tready,
  // player_out, held_mask, pressed_mask, released_mask, left_trigger_level,
  // right_trigger_level, left_x_level, left_y_level, right_x_level,
  // right_y_level
  output logic [143:0]  out_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [3:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);

  grc_top_state_t state_r, state_nxt;
  logic [14:0] left_dz_r;
  logic [14:0] right_dz_r;
  logic [7:0]  trig_th_r;
  logic [PlayerCount-1:0][15:0] hist_r;
  logic [1:0]  player_r;
  logic        conn_r;
  logic [15:0] held_r;
  logic [15:0] press_r;
  logic [15:0] rel_r;
  logic        out_tvalid_r;
  logic [143:0] out_tdata_r;

  logic        in_acc;
  logic        load;
  logic        lanes_idle;
  logic        cfg_wr;
  logic [1:0]  in_player;
  logic        in_conn;
  logic [15:0] in_buttons;
  logic [15:0] prev;
  grc_stick_res_t lsl_res, rsl_res;
  grc_trig_res_t  ltr_res, rtr_res;

  assign in_player  = in_tdata[1:0];
  assign in_conn    = in_tdata[2];
  assign in_buttons = in_tdata[18:3];
  assign in_acc     = in_tvalid && in_tready;
  assign lanes_idle = !lsl_res.busy && !rsl_res.busy && !ltr_res.busy && !rtr_res.busy;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_dz_r  <= LEFT_DZ_RST;
      right_dz_r <= RIGHT_DZ_RST;
      trig_th_r  <= TRIG_TH_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_LEFT_DZ:  left_dz_r  <= cfg_pwdata[14:0];
        REG_RIGHT_DZ: right_dz_r <= cfg_pwdata[14:0];
        REG_TRIG_TH:  trig_th_r  <= cfg_pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_LEFT_DZ:  cfg_prdata = {17'd0, left_dz_r};
      REG_RIGHT_DZ: cfg_prdata = {17'd0, right_dz_r};
      REG_TRIG_TH:  cfg_prdata = {24'd0, trig_th_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  // previous buttons of the reporting player, zero if untracked
  always_comb begin
    prev = 16'd0;
    for (int i = 0; i < PlayerCount; i++) begin
      if (int'(in_player) == i) begin
        prev = hist_r[i];
      end
    end
  end

  // button history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else if (in_acc) begin
      for (int i = 0; i < PlayerCount; i++) begin
        if (int'(in_player) == i) begin
          hist_r[i] <= in_conn ? in_buttons : 16'd0;
        end
      end
    end
  end

  // item fields kept while the lanes work
  always_ff @(posedge clk) begin
    if (in_acc) begin
      player_r <= in_player;
      conn_r   <= in_conn;
      held_r   <= in_buttons;
      press_r  <= in_buttons & ~prev;
      rel_r    <= prev & ~in_buttons;
    end
  end

  // lanes
  grc_stick_lane u_lsl (
    .clk(clk), .rst_n(rst_n), .start(in_acc),
    .x($signed(in_tdata[50:35])), .y($signed(in_tdata[66:51])),
    .deadzone(left_dz_r), .res(lsl_res)
  );
  grc_stick_lane u_rsl (
    .clk(clk), .rst_n(rst_n), .start(in_acc),
    .x($signed(in_tdata[82:67])), .y($signed(in_tdata[98:83])),
    .deadzone(right_dz_r), .res(rsl_res)
  );
  grc_trigger_lane u_ltr (
    .clk(clk), .rst_n(rst_n), .start(in_acc),
    .raw(in_tdata[26:19]), .threshold(trig_th_r), .res(ltr_res)
  );
  grc_trigger_lane u_rtr (
    .clk(clk), .rst_n(rst_n), .start(in_acc),
    .raw(in_tdata[34:27]), .threshold(trig_th_r), .res(rtr_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_RUN;
      S_RUN:   if (load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = (state_r == S_IDLE);
    load      = (state_r == S_RUN) && lanes_idle && (!out_tvalid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // merge lane results into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (conn_r) begin
        out_tdata_r <= {rsl_res.y_level, rsl_res.x_level, lsl_res.y_level,
                        lsl_res.x_level, rtr_res.level, ltr_res.level,
                        rel_r, press_r, held_r, player_r};
      end else begin
        out_tdata_r <= {142'd0, player_r};
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `GRC_ASSERT_IMP(a_no_take_while_run, state_r == S_RUN, !in_tready,
    "report taken while lanes busy")
  `GRC_ASSERT_NXT(a_result_shows, state_r == S_RUN && lanes_idle && !out_tvalid_r,
    out_tvalid_r, "finished result not presented")
  `GRC_ASSERT_NXT(a_disc_clears, in_acc && !in_conn && in_player == 2'd0,
    hist_r[0] == 16'd0, "disconnect did not clear history")
  `GRC_ASSERT_NXT(a_hist_loads, in_acc && in_conn && in_player == 2'd0,
    hist_r[0] == $past(in_buttons), "history not updated")

endmodule

// ----- tb/tb.sv -----
// self-checking testbench of the gamepad report conditioner
// depends on grc_pkg and gamepad_report_conditioner; drives in_/out_ streams and apb
`timescale 1ns / 1ps
module tb
  import grc_pkg::*;
();

  typedef struct packed {
    logic [15:0] ry;
    logic [15:0] rx;
    logic [15:0] ly;
    logic [15:0] lx;
    logic [7:0]  rt;
    logic [7:0]  lt;
    logic [15:0] buttons;
    logic        connected;
    logic [1:0]  player;
  } report_t;

  typedef struct packed {
    logic [15:0] ry;
    logic [15:0] rx;
    logic [15:0] ly;
    logic [15:0] lx;
    logic [14:0] rt;
    logic [14:0] lt;
    logic [15:0] released;
    logic [15:0] pressed;
    logic [15:0] held;
    logic [1:0]  player;
  } level_t;

  logic         clk;
  logic         rst_n;
  logic [103:0] in_tdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] out_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [3:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  gamepad_report_conditioner u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // predictor state
  logic [15:0] last_buttons [4];
  logic [14:0] left_dz, right_dz;
  logic [7:0]  trig_th;

  level_t expected_levels [$];
  int     error_count;
  int     result_count;
  bit     idle_free;

  initial begin
    clk = 1'b0;
  end
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] isqrt(logic [31:0] s);
    logic [31:0] root, bitv;
    root = 0;
    bitv = 32'h4000_0000;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s = s - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [14:0] trigger_level(logic [7:0] v, logic [7:0] t);
    logic [31:0] q;
    if (v <= t || t == 8'hFF) return '0;
    q = ((32'(v) - 32'(t)) * 32'd32768) / (32'd255 - 32'(t));
    if (q > 32767) q = 32767;
    return q[14:0];
  endfunction

  // radial deadzone of one stick, returns {y, x}
  function automatic logic [31:0] stick_levels(logic signed [15:0] x, logic signed [15:0] y,
                                               logic [14:0] dz);
    logic [31:0] ax, ay, s, m, d;
    logic [63:0] den, q;
    logic [15:0] r [2];
    ax = x[15] ? 32'(-32'(x)) : 32'(x);
    ay = y[15] ? 32'(-32'(y)) : 32'(y);
    s = ax * ax + ay * ay;
    if (64'(s) <= 64'(dz) * 64'(dz)) return '0;
    m = isqrt(s);
    if (m > 32767) m = 32767;
    if (m <= 32'(dz) || dz == 15'h7FFF) return '0;
    d = m - 32'(dz);
    den = 64'd32767 * (64'd32767 - 64'(dz));
    for (int k = 0; k < 2; k++) begin
      q = (64'(k ? ay : ax) * 64'(d) * 64'd32768) / den;
      if ((k ? y[15] : x[15])) begin
        if (q > 32768) q = 32768;
        r[k] = 16'(17'h10000 - 17'(q));
      end else begin
        if (q > 32767) q = 32767;
        r[k] = q[15:0];
      end
    end
    return {r[1], r[0]};
  endfunction

  function automatic level_t condition_report(report_t rep);
    level_t lv;
    logic [15:0] prev;
    logic [31:0] ls, rs;
    lv = '0;
    lv.player = rep.player;
    if (!rep.connected) begin
      last_buttons[rep.player] = '0;
      return lv;
    end
    prev = last_buttons[rep.player];
    last_buttons[rep.player] = rep.buttons;
    lv.held = rep.buttons;
    lv.pressed = rep.buttons & ~prev;
    lv.released = prev & ~rep.buttons;
    lv.lt = trigger_level(rep.lt, trig_th);
    lv.rt = trigger_level(rep.rt, trig_th);
    ls = stick_levels(rep.lx, rep.ly, left_dz);
    rs = stick_levels(rep.rx, rep.ry, right_dz);
    {lv.ly, lv.lx} = ls;
    {lv.ry, lv.rx} = rs;
    return lv;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // random source gap; valid drops only while idling
  task automatic idle_wait();
    if (!idle_free && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // receiver: random stall, compare each transfer
  initial begin
    level_t got, want;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        result_count++;
        if (expected_levels.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = expected_levels.pop_front();
          if (got.player !== want.player) report_mismatch("player", got.player, want.player);
          if (got.held !== want.held) report_mismatch("held", got.held, want.held);
          if (got.pressed !== want.pressed) report_mismatch("pressed", got.pressed, want.pressed);
          if (got.released !== want.released)
            report_mismatch("released", got.released, want.released);
          if (got.lt !== want.lt) report_mismatch("left trigger", got.lt, want.lt);
          if (got.rt !== want.rt) report_mismatch("right trigger", got.rt, want.rt);
          if (got.lx !== want.lx) report_mismatch("left x", got.lx, want.lx);
          if (got.ly !== want.ly) report_mismatch("left y", got.ly, want.ly);
          if (got.rx !== want.rx) report_mismatch("right x", got.rx, want.rx);
          if (got.ry !== want.ry) report_mismatch("right y", got.ry, want.ry);
        end
      end
      out_tready <= idle_free || ($urandom_range(99) >= 13);
    end
  end

  // one report transfer; a typed expectation overrides the predictor's
  task automatic send_report(report_t rep, bit typed, level_t typed_lv);
    level_t lv;
    idle_wait();
    in_tdata <= 104'(rep);
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    lv = condition_report(rep);
    if (typed) begin
      if (lv !== typed_lv) report_mismatch("predictor vs table", 0, 0);
      lv = typed_lv;
    end
    expected_levels.push_back(lv);
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_LEFT_DZ:  left_dz = value[14:0];
      REG_RIGHT_DZ: right_dz = value[14:0];
      default:      trig_th = value[7:0];
    endcase
    @(posedge clk);
  endtask

  // let the block drain before touching registers
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic report_t random_report(bit mostly_live);
    report_t r;
    r.player = 2'($urandom_range(3));
    r.connected = mostly_live ? ($urandom_range(9) != 0) : 1'($urandom_range(1));
    r.buttons = 16'($urandom);
    r.lt = 8'($urandom);
    r.rt = 8'($urandom);
    r.lx = 16'($urandom);
    r.ly = 16'($urandom);
    r.rx = 16'($urandom);
    r.ry = 16'($urandom);
    // small deflections to land near the deadzone edge
    if ($urandom_range(3) == 0) begin
      r.lx = 16'($signed($urandom_range(24000)) - 12000);
      r.ly = 16'($signed($urandom_range(24000)) - 12000);
    end
    return r;
  endfunction

  // directed table: report, typed flag, typed expectation
  typedef struct {
    report_t rep;
    bit      typed;
    level_t  lv;
  } table_row_t;

  table_row_t rows [$];

  function automatic report_t mk(logic [1:0] p, logic c, logic [15:0] b, logic [7:0] lt,
                                 logic [7:0] rt, logic [15:0] lx, logic [15:0] ly,
                                 logic [15:0] rx, logic [15:0] ry);
    report_t r;
    r.player = p; r.connected = c; r.buttons = b; r.lt = lt; r.rt = rt;
    r.lx = lx; r.ly = ly; r.rx = rx; r.ry = ry;
    return r;
  endfunction

  function automatic level_t mkl(logic [1:0] p, logic [15:0] h, logic [15:0] pr,
                                 logic [15:0] rl);
    level_t l;
    l = '0;
    l.player = p; l.held = h; l.pressed = pr; l.released = rl;
    return l;
  endfunction

  task automatic run_rows();
    foreach (rows[i]) send_report(rows[i].rep, rows[i].typed, rows[i].lv);
    rows.delete();
  endtask

  initial begin
    int settings;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    error_count = 0;
    result_count = 0;
    idle_free = 1'b0;
    foreach (last_buttons[i]) last_buttons[i] = '0;
    left_dz = LEFT_DZ_RST;
    right_dz = RIGHT_DZ_RST;
    trig_th = TRIG_TH_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: centered sticks, buttons, disconnect, extremes
    rows.push_back('{mk(0, 1, 16'hFFFF, 0, 0, 0, 0, 0, 0), 1, mkl(0, 16'hFFFF, 16'hFFFF, 0)});
    rows.push_back('{mk(0, 1, 16'h00FF, 30, 30, 0, 0, 0, 0), 1, mkl(0, 16'h00FF, 0, 16'hFF00)});
    rows.push_back('{mk(0, 0, 16'hFFFF, 255, 255, 16'h7FFF, 0, 0, 0), 1, mkl(0, 0, 0, 0)});
    rows.push_back('{mk(0, 1, 16'h5555, 0, 0, 0, 0, 0, 0), 1, mkl(0, 16'h5555, 16'h5555, 0)});
    rows.push_back('{mk(3, 1, 16'hAAAA, 0, 0, 0, 0, 0, 0), 1, mkl(3, 16'hAAAA, 16'hAAAA, 0)});
    rows.push_back('{mk(1, 1, 0, 255, 31, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000), 0, '0});
    rows.push_back('{mk(2, 1, 16'h1234, 128, 254, 16'h8000, 0, 0, 16'h7FFF), 0, '0});
    rows.push_back('{mk(1, 1, 16'h8001, 0, 255, 16'd7850, 0, 0, 16'hDE0E), 0, '0});
    rows.push_back('{mk(2, 1, 0, 200, 100, 16'hFFFF, 16'h0001, 16'd5000, 16'd7000), 0, '0});
    run_rows();
    drain();

    // register extremes then random settings
    for (settings = 0; settings < 6; settings++) begin
      case (settings)
        0: begin
          write_register(REG_LEFT_DZ, 0); write_register(REG_RIGHT_DZ, 32766);
          write_register(REG_TRIG_TH, 0);
        end
        1: begin
          write_register(REG_LEFT_DZ, 32766); write_register(REG_RIGHT_DZ, 0);
          write_register(REG_TRIG_TH, 254);
        end
        2: begin
          write_register(REG_LEFT_DZ, 32767); write_register(REG_RIGHT_DZ, 32767);
          write_register(REG_TRIG_TH, 255);
        end
        default: begin
          write_register(REG_LEFT_DZ, $urandom_range(16000));
          write_register(REG_RIGHT_DZ, $urandom_range(16000));
          write_register(REG_TRIG_TH, $urandom_range(254));
        end
      endcase
      if (settings < 3) begin
        rows.push_back('{mk(1, 1, 16'hF0F0, 255, 0, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF),
                         0, '0});
        rows.push_back('{mk(2, 1, 16'h0F0F, 254, 255, 16'd1, 16'hFFFF, 16'h7FFE, 16'd0),
                         0, '0});
        run_rows();
      end
      // long stretch with no idling in one phase
      idle_free = (settings == 4);
      repeat (settings < 3 ? 40 : 120) send_report(random_report(1), 0, '0);
      repeat (settings < 3 ? 5 : 15) send_report(random_report(0), 0, '0);
      idle_free = 1'b0;
      drain();
    end

    $display("covered %0d results over six register settings, directed edges included",
             result_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
